>>> sv/rds_group_decoder_assert.svh
// Assertion macros used by the checker file of the RDS group decoder.
`ifndef RDS_GROUP_DECODER_ASSERT_SVH
`define RDS_GROUP_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RGD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rds_group_decoder: check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rds_group_decoder: check failed");

`endif

>>> sv/rgd_pkg.sv
// Shared types and constants of the RDS group decoder.
package rgd_pkg;

    localparam int NAME_CHARS  = 8;
    localparam int TEXT_CHARS  = 64;
    localparam int TEXT_WORDS  = TEXT_CHARS / 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 128;

    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [3:0] GRP_NAME  = 4'd0;
    localparam logic [3:0] GRP_TEXT  = 4'd2;
    localparam logic [3:0] GRP_CLOCK = 4'd4;

    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [4:0] MIN_PER_HALF = 5'd30;

    typedef enum logic [2:0] {
        K_NONE,
        K_CLEAR,
        K_NAME,
        K_TEXT,
        K_CLOCK
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         seg;
        logic               ver_b;
        logic               text_flag;
        logic [15:0]        blk_c;
        logic [15:0]        blk_d;
        logic signed [12:0] minutes;
        logic [16:0]        day;
        logic [3:0]         idx;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> sv/rgd_front.sv
// Front end: unpacks an input transaction and classifies it into a command.
module rgd_front (
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [rgd_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [rgd_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    input  rgd_pkg::t_q_status              i_q_status,
    output logic                            o_push,
    output rgd_pkg::t_cmd                   o_cmd
);

    logic        rds_ready;
    logic [1:0]  block_errors;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [3:0]  text_read_index;
    logic [4:0]  hours;
    logic [10:0] hour_mins;
    logic [9:0]  offset_mins;
    logic [12:0] base_mins;

    assign rds_ready       = i_s_axis_tdata[0];
    assign block_errors    = i_s_axis_tdata[2:1];
    assign block_b         = i_s_axis_tdata[18:3];
    assign block_c         = i_s_axis_tdata[34:19];
    assign block_d         = i_s_axis_tdata[50:35];
    assign text_read_index = i_s_axis_tdata[54:51];

    assign o_s_axis_tready = !i_q_status.full;
    assign o_push          = i_s_axis_tvalid && !i_q_status.full;

    assign hours       = {block_c[0], block_d[15:12]};
    assign hour_mins   = 11'(hours) * 11'(rgd_pkg::MIN_PER_HOUR);
    assign offset_mins = 10'(block_d[4:0]) * 10'(rgd_pkg::MIN_PER_HALF);
    assign base_mins   = 13'(hour_mins) + 13'(block_d[11:6]);

    always_comb begin
        o_cmd           = '0;
        o_cmd.seg       = block_b[3:0];
        o_cmd.ver_b     = block_b[11];
        o_cmd.text_flag = block_b[4];
        o_cmd.blk_c     = block_c;
        o_cmd.blk_d     = block_d;
        o_cmd.minutes   = block_d[5] ? $signed(base_mins - 13'(offset_mins))
                                     : $signed(base_mins + 13'(offset_mins));
        o_cmd.day       = {block_b[1:0], block_c[15:1]};
        o_cmd.idx       = text_read_index;
        o_cmd.kind      = rgd_pkg::K_NONE;
        if (i_s_axis_tuser[0] == rgd_pkg::OP_CLEAR) begin
            o_cmd.kind = rgd_pkg::K_CLEAR;
        end else if (rds_ready && (block_errors == 2'd0)) begin
            unique case (block_b[15:12])
                rgd_pkg::GRP_NAME:  o_cmd.kind = rgd_pkg::K_NAME;
                rgd_pkg::GRP_TEXT:  o_cmd.kind = rgd_pkg::K_TEXT;
                rgd_pkg::GRP_CLOCK: o_cmd.kind = rgd_pkg::K_CLOCK;
                default:            o_cmd.kind = rgd_pkg::K_NONE;
            endcase
        end
    end

endmodule

>>> sv/rgd_queue.sv
// Short command queue between the front end and the executor.
module rgd_queue #(
    parameter int DEPTH = rgd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rgd_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output rgd_pkg::t_cmd      o_cmd,
    output rgd_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgd_pkg::t_cmd r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    assign o_cmd          = r_slot[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

>>> sv/rgd_back.sv
// Executor: applies commands to the name, text and clock stores and registers the result.
module rgd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rgd_pkg::t_q_status               i_q_status,
    input  rgd_pkg::t_cmd                    i_cmd,
    output logic                             o_pop,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [rgd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    logic [7:0]         r_name [rgd_pkg::NAME_CHARS];
    logic [7:0]         n_name [rgd_pkg::NAME_CHARS];
    logic [31:0]        r_text [rgd_pkg::TEXT_WORDS];
    logic [31:0]        n_text [rgd_pkg::TEXT_WORDS];
    logic               r_flag, n_flag;
    logic signed [12:0] r_min, n_min;
    logic [16:0]        r_day, n_day;
    logic               r_valid, n_valid;
    logic [rgd_pkg::OUT_DATA_W-1:0] r_data, n_data;

    logic [2:0]  name_hi;
    logic [2:0]  name_lo;
    logic [7:0]  new_hi;
    logic [7:0]  new_lo;
    logic        name_conflict;
    logic [3:0]  half_word;
    logic [63:0] res_name;
    logic [31:0] res_word;

    assign o_pop   = !i_q_status.empty && (!r_valid || i_m_axis_tready);
    assign name_hi = {i_cmd.seg[1:0], 1'b0};
    assign name_lo = {i_cmd.seg[1:0], 1'b1};
    assign new_hi  = i_cmd.blk_d[15:8];
    assign new_lo  = i_cmd.blk_d[7:0];
    assign name_conflict = ((r_name[name_hi] != 8'd0) && (r_name[name_hi] != new_hi)) ||
                           ((r_name[name_lo] != 8'd0) && (r_name[name_lo] != new_lo));
    assign half_word = {1'b0, i_cmd.seg[3:1]};

    always_comb begin
        n_name = r_name;
        n_text = r_text;
        n_flag = r_flag;
        n_min  = r_min;
        n_day  = r_day;
        if (o_pop) begin
            unique case (i_cmd.kind)
                rgd_pkg::K_CLEAR: begin
                    for (int k = 0; k < rgd_pkg::NAME_CHARS; k++) n_name[k] = 8'd0;
                    for (int k = 0; k < rgd_pkg::TEXT_WORDS; k++) n_text[k] = 32'd0;
                end
                rgd_pkg::K_NAME: begin
                    // wipe the whole name when a stored character is replaced
                    if (name_conflict) begin
                        for (int k = 0; k < rgd_pkg::NAME_CHARS; k++) n_name[k] = 8'd0;
                    end
                    n_name[name_hi] = new_hi;
                    n_name[name_lo] = new_lo;
                end
                rgd_pkg::K_TEXT: begin
                    if (i_cmd.text_flag != r_flag) begin
                        for (int k = 0; k < rgd_pkg::TEXT_WORDS; k++) n_text[k] = 32'd0;
                    end
                    n_flag = i_cmd.text_flag;
                    if (!i_cmd.ver_b) begin
                        n_text[i_cmd.seg] = {i_cmd.blk_c, i_cmd.blk_d};
                    end else if (!i_cmd.seg[0]) begin
                        n_text[half_word][31:16] = i_cmd.blk_d;
                    end else begin
                        n_text[half_word][15:0] = i_cmd.blk_d;
                    end
                end
                rgd_pkg::K_CLOCK: begin
                    n_min = i_cmd.minutes;
                    n_day = i_cmd.day;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res_name = '0;
        for (int k = 0; k < rgd_pkg::NAME_CHARS; k++) begin
            res_name[63 - 8 * k -: 8] = n_name[k];
        end
        res_word = n_text[i_cmd.idx];
        n_data   = {1'b0, (n_min != 13'sd0), n_day, n_min, res_word, res_name};
        n_valid  = o_pop ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rgd_pkg::NAME_CHARS; k++) r_name[k] <= 8'd0;
            for (int k = 0; k < rgd_pkg::TEXT_WORDS; k++) r_text[k] <= 32'd0;
            r_flag  <= 1'b0;
            r_min   <= 13'sd0;
            r_day   <= 17'd0;
            r_valid <= 1'b0;
        end else begin
            r_name  <= n_name;
            r_text  <= n_text;
            r_flag  <= n_flag;
            r_min   <= n_min;
            r_day   <= n_day;
            r_valid <= n_valid;
        end
    end

    // hold the result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

endmodule

>>> sv/rds_group_decoder.sv
// Top level of the RDS group decoder: front end, command queue and executor.
//
//  channel   dir  tdata fields (low bit up)                          tuser
//  s_axis    in   rds_ready, block_errors, block_b, block_c,         opcode
//                 block_d, text_read_index (56 bits)
//  m_axis    out  station_name, text_word, local_minutes, day_code,  -
//                 time_valid (128 bits)
//
// One transaction in and one out per cycle unless the output stalls; a result
// goes through the queue slot and then the executor's output register, the store
// update being the single stage of work. Reset clears all stores and the queue.
// A stalled output holds its result while up to QUEUE_DEPTH commands wait.
module rds_group_decoder #(
    parameter int QUEUE_DEPTH = rgd_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // rds_ready, block_errors, block_b, block_c, block_d, text_read_index
    input  logic [rgd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // opcode
    input  logic [rgd_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // station_name, text_word, local_minutes, day_code, time_valid
    output logic [rgd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    rgd_pkg::t_cmd      push_cmd;
    rgd_pkg::t_cmd      head_cmd;
    rgd_pkg::t_q_status q_status;
    logic               push;
    logic               pop;

    rgd_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    rgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    rgd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> sv/rgd_checker.sv
// Port-level checks of the RDS group decoder, bound to the top level.
`include "rds_group_decoder_assert.svh"

module rgd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [rgd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    // a stalled result holds
    `RGD_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // the queue only fills behind a waiting result
    `RGD_ASSERT_IMP(a_full_needs_stall, !o_s_axis_tready, o_m_axis_tvalid)

    // a full queue stays full while the output stalls
    `RGD_ASSERT_NEXT(a_full_holds, !o_s_axis_tready && o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready)

    // a fresh result follows an accepted input transaction, through the queue slot and the executor register
    `RGD_ASSERT_IMP(a_out_latency, $rose(o_m_axis_tvalid), $past(i_s_axis_tvalid && o_s_axis_tready, 2))

endmodule

bind rds_group_decoder rgd_checker u_rgd_checker (.*);

>>> tb/rds_group_decoder_tb.sv
// Self-checking testbench for the RDS group decoder: directed table, random groups, scoreboard.
`timescale 1ns / 100ps

module rds_group_decoder_tb;

    localparam int HALF_PERIOD    = 4;
    localparam int RANDOM_PER_SET = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 4000;

    localparam logic       OP_DEC  = rgd_pkg::OP_DECODE;
    localparam logic       OP_CLR  = rgd_pkg::OP_CLEAR;
    localparam logic [3:0] G_NAME  = rgd_pkg::GRP_NAME;
    localparam logic [3:0] G_TEXT  = rgd_pkg::GRP_TEXT;
    localparam logic [3:0] G_CLOCK = rgd_pkg::GRP_CLOCK;

    typedef struct packed {
        logic        op;
        logic        rdy;
        logic [1:0]  errs;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [3:0]  idx;
    } t_rds_item;

    typedef struct packed {
        logic [63:0] name;
        logic [31:0] word;
        logic [12:0] minutes;
        logic [16:0] day;
        logic        valid;
    } t_rds_view;

    typedef struct packed {
        t_rds_item stim;
        logic      typed;
        t_rds_view want;
    } t_dir_row;

    localparam t_rds_view ZERO_VIEW = '0;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // rds_ready, block_errors, block_b, block_c, block_d, text_read_index
    logic [rgd_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // opcode
    logic [rgd_pkg::IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // station_name, text_word, local_minutes, day_code, time_valid
    logic [rgd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;

    // decoder state as the scoreboard sees it
    logic [7:0]  ps_name [rgd_pkg::NAME_CHARS];
    logic [7:0]  rt_text [rgd_pkg::TEXT_CHARS];
    logic        rt_ab_flag = 1'b0;
    logic [12:0] ct_minutes = '0;
    logic [16:0] ct_day = '0;

    t_rds_view expected_views [$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        quiet_cycles = 0;

    t_dir_row directed_rows [0:24] = '{
        '{'{OP_DEC, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0}, 1'b1, ZERO_VIEW},
        '{'{OP_DEC, 1'b1, 2'd3, 16'h0000, 16'h0000, 16'h4142, 4'd0}, 1'b1, ZERO_VIEW},
        '{'{OP_DEC, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h4142, 4'd0}, 1'b1, ZERO_VIEW},
        '{'{OP_DEC, 1'b1, 2'd2, {G_CLOCK, 12'h003}, 16'hFFFF, 16'hFFDF, 4'd0},
          1'b1, ZERO_VIEW},
        '{'{OP_DEC, 1'b1, 2'd0, {G_NAME, 12'h000}, 16'h0000, 16'h4142, 4'd0},
          1'b1, '{64'h4142_0000_0000_0000, 32'h0, 13'h0, 17'h0, 1'b0}},
        '{'{OP_DEC, 1'b1, 2'd0, {G_NAME, 12'h003}, 16'h0000, 16'h4748, 4'd7}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_NAME, 12'h001}, 16'h0000, 16'h4344, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_NAME, 12'h000}, 16'h0000, 16'h5A42, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, 16'h1000, 16'h1234, 16'h5678, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h000}, 16'h4142, 16'h4344, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h00F}, 16'hFFFF, 16'hFFFF, 4'd15}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h805}, 16'h0000, 16'h5859, 4'd2}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h80F}, 16'hFFFF, 16'h7A7B, 4'd7}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h010}, 16'h6162, 16'h6364, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h810}, 16'h0000, 16'h6566, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_TEXT, 12'h800}, 16'h0000, 16'h6768, 4'd0}, 1'b0, '0},
        '{'{OP_CLR, 1'b0, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15}, 1'b1, ZERO_VIEW},
        '{'{OP_DEC, 1'b1, 2'd0, {G_CLOCK, 12'h003}, 16'hFFFF, 16'hFFDF, 4'd0},
          1'b1, '{64'h0, 32'h0, 13'h0B25, 17'h1FFFF, 1'b1}},
        '{'{OP_DEC, 1'b1, 2'd0, {G_CLOCK, 12'h000}, 16'h0000, 16'h003F, 4'd0},
          1'b1, '{64'h0, 32'h0, 13'h1C5E, 17'h0, 1'b1}},
        '{'{OP_DEC, 1'b1, 2'd0, {G_NAME, 12'h002}, 16'h0000, 16'h4142, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_CLOCK, 12'h000}, 16'h0000, 16'h0000, 4'd0}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, {G_CLOCK, 12'h001}, 16'hABCD, 16'h9ABC, 4'd5}, 1'b0, '0},
        '{'{OP_CLR, 1'b1, 2'd0, {G_TEXT, 12'h000}, 16'h1111, 16'h2222, 4'd3}, 1'b0, '0},
        '{'{OP_DEC, 1'b1, 2'd0, 16'h3000, 16'h5555, 16'hAAAA, 4'd9}, 1'b0, '0}
    };

    rds_group_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Update the decoder state with one group and return what the block must show.
    function automatic t_rds_view apply_group(t_rds_item it);
        int        pos;
        int        total;
        int        shift;
        t_rds_view v;
        v = '0;
        if (it.op == OP_CLR) begin
            foreach (ps_name[k]) ps_name[k] = 8'h00;
            foreach (rt_text[k]) rt_text[k] = 8'h00;
        end else if (it.rdy && it.errs == 2'd0) begin
            case (it.b[15:12])
                G_NAME: begin
                    pos = int'(it.b[1:0]) * 2;
                    if ((ps_name[pos] != 8'h00 && ps_name[pos] != it.d[15:8]) ||
                        (ps_name[pos+1] != 8'h00 && ps_name[pos+1] != it.d[7:0])) begin
                        foreach (ps_name[k]) ps_name[k] = 8'h00;
                    end
                    ps_name[pos]   = it.d[15:8];
                    ps_name[pos+1] = it.d[7:0];
                end
                G_TEXT: begin
                    // drop the whole text when the A/B flag toggles
                    if (it.b[4] != rt_ab_flag) begin
                        foreach (rt_text[k]) rt_text[k] = 8'h00;
                    end
                    rt_ab_flag = it.b[4];
                    if (!it.b[11]) begin
                        pos = int'(it.b[3:0]) * 4;
                        rt_text[pos]   = it.c[15:8];
                        rt_text[pos+1] = it.c[7:0];
                        rt_text[pos+2] = it.d[15:8];
                        rt_text[pos+3] = it.d[7:0];
                    end else begin
                        pos = int'(it.b[3:0]) * 2;
                        rt_text[pos]   = it.d[15:8];
                        rt_text[pos+1] = it.d[7:0];
                    end
                end
                G_CLOCK: begin
                    total = int'({it.c[0], it.d[15:12]}) * int'(rgd_pkg::MIN_PER_HOUR) +
                            int'(it.d[11:6]);
                    shift = int'(it.d[4:0]) * int'(rgd_pkg::MIN_PER_HALF);
                    total = it.d[5] ? total - shift : total + shift;
                    ct_minutes = total[12:0];
                    ct_day     = {it.b[1:0], it.c[15:1]};
                end
                default: ;
            endcase
        end
        for (int k = 0; k < rgd_pkg::NAME_CHARS; k++) v.name = {v.name[55:0], ps_name[k]};
        for (int k = 0; k < 4; k++) v.word = {v.word[23:0], rt_text[int'(it.idx) * 4 + k]};
        v.minutes = ct_minutes;
        v.day     = ct_day;
        v.valid   = (ct_minutes != 13'd0);
        return v;
    endfunction

    // Mostly well-formed groups; the rest is noise, dropped groups and clears.
    function automatic t_rds_item random_group();
        int          pick;
        logic        flag;
        logic [63:0] rnd;
        t_rds_item   it;
        rnd = {$urandom, $urandom};
        it = rnd[$bits(t_rds_item)-1:0];
        it.op   = OP_DEC;
        it.rdy  = 1'b1;
        it.errs = 2'd0;
        pick = $urandom_range(99);
        if (pick < 3) begin
            it.op = OP_CLR;
        end else if (pick < 13) begin
            it.op   = $urandom_range(1) ? OP_CLR : OP_DEC;
            it.rdy  = 1'($urandom_range(1));
            it.errs = 2'($urandom_range(3));
        end else if (pick < 20) begin
            it.b[15:12] = $urandom_range(2) == 0 ? G_NAME : ($urandom_range(1) ? G_TEXT
                                                                              : G_CLOCK);
            if ($urandom_range(1)) it.rdy = 1'b0;
            else it.errs = 2'($urandom_range(3, 1));
        end else if (pick < 25) begin
            it.b[15:12] = 4'($urandom_range(15));
        end else if (pick < 55) begin
            // a small alphabet makes repeats and name changes both common
            it.b[15:12] = G_NAME;
            it.d[15:8] = $urandom_range(4) == 0 ? 8'h00 : 8'h41 + 8'($urandom_range(2));
            it.d[7:0]  = $urandom_range(4) == 0 ? 8'h00 : 8'h41 + 8'($urandom_range(2));
        end else if (pick < 85) begin
            it.b[15:12] = G_TEXT;
            flag = ($urandom_range(9) == 0) ? ~rt_ab_flag : rt_ab_flag;
            it.b[4] = flag;
        end else begin
            it.b[15:12] = G_CLOCK;
        end
        return it;
    endfunction

    task automatic send_group(input t_rds_item it, input logic typed, input t_rds_view want);
        t_rds_view v;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, it.idx, it.d, it.c, it.b, it.errs, it.rdy};
        i_s_axis_tuser  <= it.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        v = apply_group(it);
        expected_views.push_back(typed ? want : v);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // scoreboard: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_rds_view want;
        t_rds_view got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.name    = o_m_axis_tdata[63:0];
            got.word    = o_m_axis_tdata[95:64];
            got.minutes = o_m_axis_tdata[108:96];
            got.day     = o_m_axis_tdata[125:109];
            got.valid   = o_m_axis_tdata[126];
            if (expected_views.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none got %h", $time, o_m_axis_tdata);
            end else begin
                want = expected_views.pop_front();
                check_field("station_name", want.name, got.name);
                check_field("text_word", 64'(want.word), 64'(got.word));
                check_field("local_minutes", 64'(want.minutes), 64'(got.minutes));
                check_field("day_code", 64'(want.day), 64'(got.day));
                check_field("time_valid", 64'(want.valid), 64'(got.valid));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int idle_sets [4][2];
        idle_sets = '{'{0, 0}, '{76, 0}, '{0, 76}, '{31, 31}};
        foreach (ps_name[k]) ps_name[k] = 8'h00;
        foreach (rt_text[k]) rt_text[k] = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            send_group(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
        end
        for (int s = 0; s < 4; s++) begin
            send_idle_pct  = idle_sets[s][0];
            recv_stall_pct = idle_sets[s][1];
            repeat (RANDOM_PER_SET) send_group(random_group(), 1'b0, ZERO_VIEW);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        // hold a while longer to catch stray results
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> rds_group_decoder.f
+incdir+sv
sv/rgd_pkg.sv
sv/rgd_front.sv
sv/rgd_queue.sv
sv/rgd_back.sv
sv/rds_group_decoder.sv
sv/rgd_checker.sv
tb/rds_group_decoder_tb.sv
